// ===== hdl/weighted_random_select_unit_assert.svh =====
// ---------------------------------------------------------------------------
// Weighted random select assertion macros
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef WEIGHTED_RANDOM_SELECT_UNIT_ASSERT_SVH
`define WEIGHTED_RANDOM_SELECT_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WRS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("weighted_random_select_unit: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define WRS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("weighted_random_select_unit: next-cycle check failed");

`endif

// ===== hdl/wrs_pkg.sv =====
// ---------------------------------------------------------------------------
// Weighted random select package
// Command and status codes, controller states and fixed field widths.
// ---------------------------------------------------------------------------
package wrs_pkg;

  localparam int unsigned CMD_W     = 2;
  localparam int unsigned WEIGHT_W  = 16;
  localparam int unsigned RV_W      = 32;
  localparam int unsigned BIT_W     = 5;
  localparam int unsigned IDX_OUT_W = 6;
  localparam int unsigned STATUS_W  = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_DRAW   = 2'd2
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_RD,
    S_CMP,
    S_FIN
  } state_e;

endpackage

// ===== hdl/weighted_random_select_unit.sv =====
// ---------------------------------------------------------------------------
// Weighted random select unit
// Keeps running weight totals in a memory and draws an index by weight.
// ---------------------------------------------------------------------------
// Every item carries a command and produces exactly one result item. A clear
// empties the table and an append stores the new running total in the next
// entry; both go straight to the result stage, which loads the output
// register once it is free and then returns to idle. A draw reduces the
// random value to r = random_value mod total + 1 with a restoring remainder
// unit that retires one dividend bit per cycle, then runs a binary search
// over the nondecreasing running totals for the first entry that is at
// least r. Each search step takes a read state and a compare state because
// the sums memory read is registered; the draw then passes through the
// result stage like the other commands. Items are handled one at a time;
// the result sits in an output register so the unit can take the next
// item while a result still waits downstream.
// Entries of weight zero are never chosen, and a draw on a zero total
// returns index zero with the empty status.

`include "weighted_random_select_unit_assert.svh"

module weighted_random_select_unit
  import wrs_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [CMD_W-1:0]     cmd_i,
  input  logic [WEIGHT_W-1:0]  weight_i,
  input  logic [RV_W-1:0]      random_value_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [IDX_OUT_W-1:0] chosen_index_o,
  output logic [STATUS_W-1:0]  status_o
);

  // Index, count and sum widths. The total of MAX_ENTRIES full-scale
  // weights always fits in SUM_W bits.
  localparam int unsigned IDX_W = $clog2(MAX_ENTRIES);
  localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned SUM_W = WEIGHT_W + $clog2(MAX_ENTRIES);

  localparam logic [CNT_W-1:0] CountFull = CNT_W'(MAX_ENTRIES);
  localparam logic [BIT_W-1:0] BitLast   = BIT_W'(RV_W - 1);

  // Running totals memory: one write port, one registered read port.
  logic [SUM_W-1:0] sums_mem [MAX_ENTRIES];
  logic [SUM_W-1:0] rd_q;
  logic             mem_we;
  logic [IDX_W-1:0] rd_addr;

  // Control state.
  state_e           state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [SUM_W-1:0] total_q, total_d;
  logic             out_valid_q, out_valid_d;

  // Datapath registers. rem_q holds the partial remainder during the
  // reduction and the search target r afterwards.
  logic [SUM_W-1:0]     rem_q, rem_d;
  logic [RV_W-1:0]      dvd_q, dvd_d;
  logic [BIT_W-1:0]     bit_q, bit_d;
  logic [IDX_W-1:0]     lo_q, lo_d;
  logic [IDX_W-1:0]     hi_q, hi_d;
  logic [IDX_W-1:0]     res_idx_q, res_idx_d;
  status_e              res_st_q, res_st_d;
  logic [IDX_OUT_W-1:0] out_idx_q, out_idx_d;
  status_e              out_st_q, out_st_d;

  // Combinational helpers.
  logic [SUM_W-1:0] app_sum;
  logic [IDX_W:0]   mid_sum;
  logic [IDX_W-1:0] mid;
  logic [SUM_W:0]   shifted;
  logic [SUM_W:0]   diff;
  logic             ge;
  logic [SUM_W-1:0] new_rem;
  logic             out_free;

  assign app_sum = total_q + SUM_W'(weight_i);
  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid     = mid_sum[IDX_W:1];
  assign rd_addr = mid;

  // One restoring step: bring in the next dividend bit, subtract the total
  // if it fits. The partial remainder stays below the total.
  assign shifted = {rem_q, dvd_q[RV_W-1]};
  assign diff    = shifted - {1'b0, total_q};
  assign ge      = (shifted >= {1'b0, total_q});
  assign new_rem = ge ? diff[SUM_W-1:0] : shifted[SUM_W-1:0];

  assign out_free = !out_valid_q || !out_stall_i;

  // The unit takes an item only from idle; every item moves through the
  // result stage before the next one is taken.
  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    total_d     = total_q;
    out_valid_d = out_valid_q;
    rem_d       = rem_q;
    dvd_d       = dvd_q;
    bit_d       = bit_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    res_idx_d   = res_idx_q;
    res_st_d    = res_st_q;
    out_idx_d   = out_idx_q;
    out_st_d    = out_st_q;
    mem_we      = 1'b0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          res_idx_d = '0;
          res_st_d  = ST_OK;
          state_d   = S_FIN;
          case (cmd_i)
            CMD_CLEAR: begin
              count_d = '0;
              total_d = '0;
            end
            CMD_APPEND: begin
              if (count_q == CountFull) begin
                res_st_d = ST_FULL;
              end else begin
                mem_we  = 1'b1;
                total_d = app_sum;
                count_d = count_q + CNT_W'(1);
              end
            end
            CMD_DRAW: begin
              if (total_q == '0) begin
                res_st_d = ST_EMPTY;
              end else begin
                rem_d   = '0;
                dvd_d   = random_value_i;
                bit_d   = '0;
                state_d = S_DIV;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_DIV: begin
        rem_d = new_rem;
        dvd_d = dvd_q << 1;
        bit_d = bit_q + BIT_W'(1);
        if (bit_q == BitLast) begin
          rem_d   = new_rem + SUM_W'(1);
          lo_d    = '0;
          hi_d    = IDX_W'(count_q - CNT_W'(1));
          state_d = S_RD;
        end
      end
      S_RD: begin
        if (lo_q == hi_q) begin
          res_idx_d = lo_q;
          state_d   = S_FIN;
        end else begin
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        if (rd_q >= rem_q) begin
          hi_d = mid;
        end else begin
          lo_d = mid + IDX_W'(1);
        end
        state_d = S_RD;
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_idx_d   = IDX_OUT_W'(res_idx_q);
          out_st_d    = res_st_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q     <= rem_d;
    dvd_q     <= dvd_d;
    bit_q     <= bit_d;
    lo_q      <= lo_d;
    hi_q      <= hi_d;
    res_idx_q <= res_idx_d;
    res_st_q  <= res_st_d;
    out_idx_q <= out_idx_d;
    out_st_q  <= out_st_d;
  end

  // Writes happen only when an append is accepted; the read port runs always,
  // but its data is used only in a later draw search, so no used read meets a write.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      sums_mem[count_q[IDX_W-1:0]] <= app_sum;
    end
    rd_q <= sums_mem[rd_addr];
  end

  assign out_valid_o    = out_valid_q;
  assign chosen_index_o = out_idx_q;
  assign status_o       = out_st_q;

  // The table never holds more than its capacity, and an empty table has
  // a zero total.
  `WRS_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CountFull)
  `WRS_ASSERT_NOW(a_empty_total, count_q == '0, total_q == '0)
  // The search window stays ordered and inside the filled part of the table.
  `WRS_ASSERT_NOW(a_search_window, (state_q == S_RD) || (state_q == S_CMP),
                  (lo_q <= hi_q) && ({1'b0, hi_q} < count_q))
  // An accepted append to a table with room grows it by exactly one entry.
  `WRS_ASSERT_NEXT(a_append_grow,
                   in_valid_i && !in_stall_o && (cmd_i == CMD_APPEND) &&
                   (count_q != CountFull),
                   count_q == $past(count_q) + CNT_W'(1))

endmodule
